>>> design/tun_pkg.sv
`default_nettype none
package tun_pkg;

  localparam int CW     = 16;   // input coordinate width
  localparam int PW     = 17;   // edge component width
  localparam int PRW    = 34;   // edge product width
  localparam int RW     = 35;   // cross product component width
  localparam int MAGW   = 34;   // |r| component width
  localparam int HALFW  = 17;   // split point for the square
  localparam int PPW    = 34;   // partial product width
  localparam int SQ_W   = 67;   // mag^2
  localparam int SUM_W  = 68;   // sum of squares
  localparam int RHS_W  = 97;   // mag^2 << 30
  localparam int RHS_SH = 30;
  localparam int A_W    = 100;  // (2m)^2 * sum
  localparam int B_W    = 84;   // 2m * sum
  localparam int T_W    = 101;  // trial compare width
  localparam int M_W    = 15;   // quotient magnitude bits
  localparam int NBITS  = 15;   // one cell per quotient bit
  localparam int BI_W   = 4;    // bit index width
  localparam int OW     = 16;   // output component width

  typedef struct packed {
    logic [A_W-1:0]   acc_a;
    logic [B_W-1:0]   acc_b;
    logic [RHS_W-1:0] rhs;
    logic [M_W-1:0]   m;
    logic             neg;
  } comp_t;

  typedef struct packed {
    comp_t [2:0]      comp;
    logic [SUM_W-1:0] sum;
    logic             degen;
  } cell_t;

endpackage
`default_nettype wire

>>> design/tun_front.sv
`default_nettype none
module tun_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic signed [tun_pkg::CW-1:0]      a [3],
  input  wire logic signed [tun_pkg::CW-1:0]      b [3],
  input  wire logic signed [tun_pkg::CW-1:0]      c [3],
  output logic                                    out_valid,
  output logic [tun_pkg::SQ_W-1:0]                sq [3],
  output logic [2:0]                              neg,
  output logic [tun_pkg::SUM_W-1:0]               sum
);

  logic [5:0] v_r;

  logic signed [tun_pkg::PW-1:0]  p_r [3];
  logic signed [tun_pkg::PW-1:0]  q_r [3];
  logic signed [tun_pkg::PRW-1:0] pr_pos_r [3];
  logic signed [tun_pkg::PRW-1:0] pr_neg_r [3];
  logic [tun_pkg::MAGW-1:0]       mag_r [3];
  logic [2:0]                     neg3_r, neg4_r, neg5_r, neg6_r;
  logic [tun_pkg::PPW-1:0]        hh_r [3];
  logic [tun_pkg::PPW-1:0]        hl_r [3];
  logic [tun_pkg::PPW-1:0]        ll_r [3];
  logic [tun_pkg::SQ_W-1:0]       sq5_r [3];
  logic [tun_pkg::SQ_W-1:0]       sq6_r [3];
  logic [tun_pkg::SUM_W-1:0]      sum_r;

  logic signed [tun_pkg::RW-1:0]  r_nxt [3];
  logic [tun_pkg::HALFW-1:0]      hi_w [3];
  logic [tun_pkg::HALFW-1:0]      lo_w [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_nxt[i] = tun_pkg::RW'(pr_pos_r[i]) - tun_pkg::RW'(pr_neg_r[i]);
      hi_w[i]  = mag_r[i][tun_pkg::MAGW-1:tun_pkg::HALFW];
      lo_w[i]  = mag_r[i][tun_pkg::HALFW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= tun_pkg::PW'(a[i]) - tun_pkg::PW'(b[i]);
        q_r[i] <= tun_pkg::PW'(c[i]) - tun_pkg::PW'(b[i]);
      end
      // r = p x q, two products per component
      pr_pos_r[0] <= p_r[1] * q_r[2];
      pr_neg_r[0] <= p_r[2] * q_r[1];
      pr_pos_r[1] <= p_r[2] * q_r[0];
      pr_neg_r[1] <= p_r[0] * q_r[2];
      pr_pos_r[2] <= p_r[0] * q_r[1];
      pr_neg_r[2] <= p_r[1] * q_r[0];
      for (int i = 0; i < 3; i++) begin
        neg3_r[i] <= r_nxt[i][tun_pkg::RW-1];
        mag_r[i]  <= r_nxt[i][tun_pkg::RW-1] ? tun_pkg::MAGW'(-r_nxt[i])
                                             : tun_pkg::MAGW'(r_nxt[i]);
        hh_r[i]   <= hi_w[i] * hi_w[i];
        hl_r[i]   <= hi_w[i] * lo_w[i];
        ll_r[i]   <= lo_w[i] * lo_w[i];
        sq5_r[i]  <= (tun_pkg::SQ_W'(hh_r[i]) << (2 * tun_pkg::HALFW))
                   + (tun_pkg::SQ_W'(hl_r[i]) << (tun_pkg::HALFW + 1))
                   + tun_pkg::SQ_W'(ll_r[i]);
        sq6_r[i]  <= sq5_r[i];
      end
      neg4_r <= neg3_r;
      neg5_r <= neg4_r;
      neg6_r <= neg5_r;
      sum_r  <= tun_pkg::SUM_W'(sq5_r[0]) + tun_pkg::SUM_W'(sq5_r[1])
              + tun_pkg::SUM_W'(sq5_r[2]);
    end
  end

  assign out_valid = v_r[5];
  assign sq        = sq6_r;
  assign neg       = neg6_r;
  assign sum       = sum_r;

endmodule
`default_nettype wire

>>> design/tun_cell.sv
`default_nettype none
module tun_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [tun_pkg::BI_W-1:0]   bit_idx,
  input  wire tun_pkg::cell_t             d_in,
  output logic                            out_valid,
  output tun_pkg::cell_t                  d_out
);

  logic            valid_r;
  tun_pkg::cell_t  d_r, d_nxt;

  logic [tun_pkg::BI_W:0]  sh1;
  logic [tun_pkg::BI_W:0]  sh2;
  logic [tun_pkg::T_W-1:0] sum_t;
  logic [tun_pkg::T_W-1:0] a_t [3];
  logic [tun_pkg::T_W-1:0] b_t [3];
  logic [tun_pkg::T_W-1:0] keep_t [3];
  logic [tun_pkg::T_W-1:0] trial [3];
  logic                    pass [3];

  // trial m' = m + 2^j, d = 2^(j+1):
  //   (2m'-1)^2 sum = A + (2d-2)B + (d-1)^2 sum
  always_comb begin
    sh1   = tun_pkg::BI_W'(bit_idx) + (tun_pkg::BI_W+1)'(2);
    sh2   = {bit_idx, 1'b0} + (tun_pkg::BI_W+1)'(2);
    sum_t = tun_pkg::T_W'(d_in.sum);
    d_nxt = d_in;
    for (int i = 0; i < 3; i++) begin
      a_t[i]    = tun_pkg::T_W'(d_in.comp[i].acc_a);
      b_t[i]    = tun_pkg::T_W'(d_in.comp[i].acc_b);
      keep_t[i] = a_t[i] + (b_t[i] << sh1) + (sum_t << sh2);
      trial[i]  = keep_t[i] - (b_t[i] << 1) - (sum_t << sh1) + sum_t;
      pass[i]   = trial[i] <= tun_pkg::T_W'(d_in.comp[i].rhs);
      if (pass[i]) begin
        d_nxt.comp[i].acc_a = tun_pkg::A_W'(keep_t[i]);
        d_nxt.comp[i].acc_b = d_in.comp[i].acc_b
                            + (tun_pkg::B_W'(d_in.sum) << (bit_idx + tun_pkg::BI_W'(1)));
        d_nxt.comp[i].m     = d_in.comp[i].m | (tun_pkg::M_W'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign d_out     = d_r;

endmodule
`default_nettype wire

>>> design/triangle_unit_normal.sv
// Pipeline from input transaction to out_valid: 6 front stages, 15 cells, 1 output reg.
// One triangle per cycle while out_ready does not stall it; every stage is a register, no unit is shared.
// The pipeline advances as a whole: in_ready = !out_valid || out_ready.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module triangle_unit_normal (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_a_x,
  input  wire logic signed [15:0] in_a_y,
  input  wire logic signed [15:0] in_a_z,
  input  wire logic signed [15:0] in_b_x,
  input  wire logic signed [15:0] in_b_y,
  input  wire logic signed [15:0] in_b_z,
  input  wire logic signed [15:0] in_c_x,
  input  wire logic signed [15:0] in_c_y,
  input  wire logic signed [15:0] in_c_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_norm_x,
  output logic signed [15:0]      out_norm_y,
  output logic signed [15:0]      out_norm_z,
  output logic                    out_degenerate
);

  // Global advance: a waiting result stalls everything, else all stages shift.
  logic en;

  logic signed [tun_pkg::CW-1:0] va [3];
  logic signed [tun_pkg::CW-1:0] vb [3];
  logic signed [tun_pkg::CW-1:0] vc [3];

  logic                        fr_valid;
  logic [tun_pkg::SQ_W-1:0]    fr_sq [3];
  logic [2:0]                  fr_neg;
  logic [tun_pkg::SUM_W-1:0]   fr_sum;

  tun_pkg::cell_t              seed;
  tun_pkg::cell_t              chain_d [tun_pkg::NBITS+1];
  logic                        chain_v [tun_pkg::NBITS+1];

  logic                         out_valid_r;
  logic signed [tun_pkg::OW-1:0] norm_r [3];
  logic                         degen_r;
  logic signed [tun_pkg::OW-1:0] norm_nxt [3];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign va = '{in_a_x, in_a_y, in_a_z};
  assign vb = '{in_b_x, in_b_y, in_b_z};
  assign vc = '{in_c_x, in_c_y, in_c_z};

  // Edges, cross product, |r_i|^2 and their sum.
  tun_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .a         (va),
    .b         (vb),
    .c         (vc),
    .out_valid (fr_valid),
    .sq        (fr_sq),
    .neg       (fr_neg),
    .sum       (fr_sum)
  );

  // Seed the cell row: accumulators empty, compare bound mag^2 * 2^30.
  always_comb begin
    seed.sum   = fr_sum;
    seed.degen = (fr_sum == '0);
    for (int i = 0; i < 3; i++) begin
      seed.comp[i].acc_a = '0;
      seed.comp[i].acc_b = '0;
      seed.comp[i].rhs   = tun_pkg::RHS_W'(fr_sq[i]) << tun_pkg::RHS_SH;
      seed.comp[i].m     = '0;
      seed.comp[i].neg   = fr_neg[i];
    end
  end

  assign chain_d[0] = seed;
  assign chain_v[0] = fr_valid;

  // Cell k settles quotient bit (14 - k) for all three components,
  // keeping (2m)^2*sum and 2m*sum so each trial needs only shifts and adds.
  for (genvar k = 0; k < tun_pkg::NBITS; k++) begin : g_cell
    tun_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_v[k]),
      .bit_idx   (tun_pkg::BI_W'(tun_pkg::NBITS - 1 - k)),
      .d_in      (chain_d[k]),
      .out_valid (chain_v[k+1]),
      .d_out     (chain_d[k+1])
    );
  end

  // Apply sign; degenerate forces zero (all trials pass when sum is zero).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (chain_d[tun_pkg::NBITS].degen) begin
        norm_nxt[i] = '0;
      end else if (chain_d[tun_pkg::NBITS].comp[i].neg) begin
        norm_nxt[i] = -tun_pkg::OW'(chain_d[tun_pkg::NBITS].comp[i].m);
      end else begin
        norm_nxt[i] = tun_pkg::OW'(chain_d[tun_pkg::NBITS].comp[i].m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain_v[tun_pkg::NBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r  <= norm_nxt;
      degen_r <= chain_d[tun_pkg::NBITS].degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_norm_x     = norm_r[0];
  assign out_norm_y     = norm_r[1];
  assign out_norm_z     = norm_r[2];
  assign out_degenerate = degen_r;

endmodule
`default_nettype wire

>>> design/tun_chk.sv
`default_nettype none
module tun_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_norm_x,
  input wire logic signed [15:0] out_norm_y,
  input wire logic signed [15:0] out_norm_z,
  input wire logic               out_degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_norm_x)
      && $stable(out_norm_y) && $stable(out_norm_z) && $stable(out_degenerate))
    else $error("result changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_norm_x == 16'sd0 && out_norm_y == 16'sd0
      && out_norm_z == 16'sd0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_x <= 16'sd16384 && out_norm_x >= -16'sd16384
      && out_norm_y <= 16'sd16384 && out_norm_y >= -16'sd16384
      && out_norm_z <= 16'sd16384 && out_norm_z >= -16'sd16384)
    else $error("normal component out of Q1.14 range");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind triangle_unit_normal tun_chk u_tun_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_norm_x     (out_norm_x),
  .out_norm_y     (out_norm_y),
  .out_norm_z     (out_norm_z),
  .out_degenerate (out_degenerate)
);
`default_nettype wire

>>> tb/tun_checker.sv
`timescale 1ns / 100ps
module tun_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_a_x,
  input  logic signed [15:0] in_a_y,
  input  logic signed [15:0] in_a_z,
  input  logic signed [15:0] in_b_x,
  input  logic signed [15:0] in_b_y,
  input  logic signed [15:0] in_b_z,
  input  logic signed [15:0] in_c_x,
  input  logic signed [15:0] in_c_y,
  input  logic signed [15:0] in_c_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_norm_x,
  input  logic signed [15:0] out_norm_y,
  input  logic signed [15:0] out_norm_z,
  input  logic               out_degenerate,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  normal_t normal_q[$];
  int      err_cnt = 0;

  // largest m in 0..16384 with (2m-1)^2 * sum <= mag^2 * 2^30, sign applied
  function automatic logic signed [15:0] q14_component(longint r, logic [127:0] sum);
    logic [127:0] mag, rhs, lhs, k;
    int lo, hi, mid;
    mag = (r < 0) ? 128'(-r) : 128'(r);
    rhs = (mag * mag) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 128'(2 * mid - 1) * 128'(2 * mid - 1);
      lhs = sum * k;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (r < 0) ? -16'(lo) : 16'(lo);
  endfunction

  function automatic normal_t unit_normal();
    longint px, py, pz, qx, qy, qz, rx, ry, rz;
    logic [127:0] sum;
    normal_t n;
    px = longint'(in_a_x) - longint'(in_b_x);
    py = longint'(in_a_y) - longint'(in_b_y);
    pz = longint'(in_a_z) - longint'(in_b_z);
    qx = longint'(in_c_x) - longint'(in_b_x);
    qy = longint'(in_c_y) - longint'(in_b_y);
    qz = longint'(in_c_z) - longint'(in_b_z);
    rx = py * qz - pz * qy;
    ry = pz * qx - px * qz;
    rz = px * qy - py * qx;
    sum = 128'(rx < 0 ? -rx : rx) * 128'(rx < 0 ? -rx : rx)
        + 128'(ry < 0 ? -ry : ry) * 128'(ry < 0 ? -ry : ry)
        + 128'(rz < 0 ? -rz : rz) * 128'(rz < 0 ? -rz : rz);
    if (sum == 0) begin
      n.nx = 0; n.ny = 0; n.nz = 0; n.degen = 1'b1;
    end else begin
      n.nx = q14_component(rx, sum);
      n.ny = q14_component(ry, sum);
      n.nz = q14_component(rz, sum);
      n.degen = 1'b0;
    end
    return n;
  endfunction

  assign pending = normal_q.size();
  assign errors  = err_cnt;

  always @(posedge clk) begin
    normal_t want;
    if (!rst_n) begin
      normal_q.delete();
    end else begin
      if (in_valid && in_ready) normal_q = {normal_q, unit_normal()};
      if (out_valid && out_ready) begin
        if (normal_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result x=%0d y=%0d z=%0d degenerate=%0b", $time,
                   out_norm_x, out_norm_y, out_norm_z, out_degenerate);
        end else begin
          want = normal_q.pop_front();
          if (out_norm_x !== want.nx || out_norm_y !== want.ny ||
              out_norm_z !== want.nz || out_degenerate !== want.degen) begin
            err_cnt++;
            $display("%0t: mismatch expected (%0d,%0d,%0d,%0b) actual (%0d,%0d,%0d,%0b)",
                     $time, want.nx, want.ny, want.nz, want.degen,
                     out_norm_x, out_norm_y, out_norm_z, out_degenerate);
          end
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int LATENCY     = 22;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_TRIS = 1080;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_a_x = 0, in_a_y = 0, in_a_z = 0;
  logic signed [15:0] in_b_x = 0, in_b_y = 0, in_b_z = 0;
  logic signed [15:0] in_c_x = 0, in_c_y = 0, in_c_z = 0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic out_degenerate;
  int errors, pending;
  int cycles = 0;

  always #5 clk = ~clk;

  triangle_unit_normal dut (.*);

  tun_checker chk (.*);

  // watchdog: a stuck handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL triangle_unit_normal");
      $finish;
    end
  end

  // Receiver: stall mode is redrawn at random from always ready, half and quarter.
  // Once, mid-run, it holds off for a long stretch so the pipeline fills up
  // and in_ready drops while the sender keeps offering transactions.
  initial begin
    int mode, hold;
    bit held;
    mode = 0;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && cycles > 600) begin
        held = 1;
        hold = 150;
      end
      if (cycles % 16 == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Present one triangle and hold it until accepted. in_ready is sampled on the
  // falling edge, where it is settled, to decide whether the next rise takes it.
  task automatic send_tri(input logic [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    bit taken;
    in_valid <= 1'b1;
    in_a_x <= ax; in_a_y <= ay; in_a_z <= az;
    in_b_x <= bx; in_b_y <= by; in_b_z <= bz;
    in_c_x <= cx; in_c_y <= cy; in_c_z <= cz;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // gap between bursts; valid drops here and after the last triangle
  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_coord(input int span);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  initial begin
    logic [15:0] v[9];
    int burst, kind, span, s;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate cases (all zero, coincident, collinear)
    send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tri(100, -5, 7, 100, -5, 7, 3, 4, 5);
    send_tri(1, 2, 3, 0, 0, 0, 2, 4, 6);
    send_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
    // full-length components along each axis, both signs
    send_tri(64, 0, 0, 0, 0, 0, 0, 64, 0);
    send_tri(0, 64, 0, 0, 0, 0, 64, 0, 0);
    send_tri(0, 64, 0, 0, 0, 0, 0, 0, 64);
    send_tri(0, 0, 64, 0, 0, 0, 0, 64, 0);
    send_tri(0, 0, 64, 0, 0, 0, 64, 0, 0);
    send_tri(64, 0, 0, 0, 0, 0, 0, 0, 64);
    // input extremes: largest edges and cross products
    send_tri(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
             16'h8000, 16'h8000, 16'h7fff);
    send_tri(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
             16'h7fff, 16'h7fff, 16'h8000);
    send_tri(16'h7fff, 16'h8000, 0, 16'h8000, 16'h8000, 0, 16'h8000, 16'h7fff, 0);
    send_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
             16'h8000, 16'h7fff, 16'h8000);
    // tiny triangle, diagonal and rounding-tie neighborhoods
    send_tri(1, 0, 0, 0, 0, 0, 0, 1, 1);
    send_tri(1, 1, 0, 0, 0, 0, 0, 1, 1);
    send_tri(3, 0, 0, 0, 0, 0, 0, 4, 0);
    send_tri(-1, -1, -1, 0, 0, 0, 1, -1, 0);
    idle_gap(3);

    // random: mostly full-range triangles, plus small, degenerate, extreme
    s = 0;
    while (s < RANDOM_TRIS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && s < RANDOM_TRIS; i++) begin
        kind = $urandom_range(0, 9);
        span = (kind < 5) ? 32767 : (kind < 7) ? $urandom_range(1, 200) : 32767;
        foreach (v[j]) v[j] = (kind < 5) ? 16'($urandom) : rnd_coord(span);
        if (kind == 7) begin
          // degenerate: collinear or coincident
          case ($urandom_range(0, 2))
            0: for (int j = 0; j < 3; j++) v[j] = v[j + 3];
            1: for (int j = 0; j < 3; j++) v[j + 6] = v[j + 3];
            default: for (int j = 0; j < 3; j++) begin
              v[j + 3] = rnd_coord(1000);
              v[j] = v[j + 3] + rnd_coord(100);
              v[j + 6] = v[j + 3] + 16'(2 * $signed(v[j] - v[j + 3]));
            end
          endcase
        end else if (kind == 8) begin
          foreach (v[j]) v[j] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        end
        send_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
        s++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) $display("PASS triangle_unit_normal");
    else $display("FAIL triangle_unit_normal");
    $finish;
  end

endmodule
